>>> hw/rtl/oil_pkg.sv
// Shared constants and types for the ordered insert list.
// Used by oil_ram and ordered_insert_list; depends on nothing else.
`default_nettype none

package oil_pkg;

	localparam int DEPTH    = 16;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int DATA_W   = 32;
	localparam int REQ_W    = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 5;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED = 2'd0,
		ST_FULL   = 2'd1,
		ST_ELEM   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [DATA_W-1:0] data;
	} ram_wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/oil_ram.sv
// Entry store of the ordered insert list: one write port, one registered read port.
// Depends on oil_pkg.
`default_nettype none

module oil_ram (
	input  wire logic                      clk,
	input  wire oil_pkg::ram_wr_t          wr,
	input  wire logic [oil_pkg::IDX_W-1:0] rd_addr,
	output logic [oil_pkg::DATA_W-1:0]     rd_data
);
	import oil_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> hw/rtl/ordered_insert_list.sv
// Top level of the ordered insert list: request sequencer, shared comparator
// and result register. Depends on oil_pkg and oil_ram.
`default_nettype none

// Usage.
// A request word (req_type, value) is taken at a rising edge where start is
// high and busy is low. Append stores value at the tail, insert stores it
// before the first entry strictly greater than it (after any equal ones),
// and readout returns every entry in order. Request code 3 is ignored.
// Each result word is shown on status, out_value, position and last for
// exactly one cycle with strobe high; the receiver cannot stall the block, so
// nothing waits on it. last marks the final word of a request.
// All entries sit in one store with a write port and a registered read port.
// Append, insert into an empty list, and append or insert on a full list give
// their word in the cycle after acceptance. An insert at place p into n entries
// reads and compares entries from the head until one is greater or the tail
// is reached, moves every entry from p to the tail up a slot, then writes
// at p. A readout reads and then shows each entry in turn, or gives one empty
// word for an empty list. busy is high while a scan, shift or readout runs.
// Reset empties the list; the store itself is not cleared.

module ordered_insert_list (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [oil_pkg::REQ_W-1:0]    req_type,
	input  wire logic signed [oil_pkg::DATA_W-1:0] value,
	output logic                              strobe,
	output logic [oil_pkg::STATUS_W-1:0]      status,
	output logic signed [oil_pkg::DATA_W-1:0] out_value,
	output logic [oil_pkg::POS_W-1:0]         position,
	output logic                              last
);
	import oil_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SCAN_RD  = 8'b0000_0010,
		S_SCAN_CMP = 8'b0000_0100,
		S_SHIFT_RD = 8'b0000_1000,
		S_SHIFT_WR = 8'b0001_0000,
		S_PUT      = 8'b0010_0000,
		S_READ_RD  = 8'b0100_0000,
		S_READ_OUT = 8'b1000_0000
	} state_t;

	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          count_q, count_d;
	logic [CNT_W-1:0]          idx_q, idx_d;
	logic [CNT_W-1:0]          pos_q, pos_d;
	logic signed [DATA_W-1:0]  value_q, value_d;

	logic                      strobe_q, strobe_d;
	status_t                   status_q, status_d;
	logic [DATA_W-1:0]         out_value_q, out_value_d;
	logic [POS_W-1:0]          position_q, position_d;
	logic                      last_q, last_d;

	ram_wr_t                   wr;
	logic [IDX_W-1:0]          rd_addr;
	logic [DATA_W-1:0]         rd_data;
	logic                      greater;
	logic [CNT_W-1:0]          idx_inc, idx_dec;
	logic                      accept;

	oil_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The one comparator, shared by every step of the scan.
	assign greater = $signed(rd_data) > value_q;
	assign idx_inc = idx_q + CNT_W'(1);
	assign idx_dec = idx_q - CNT_W'(1);
	assign accept  = start && (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		pos_d       = pos_q;
		value_d     = value_q;
		strobe_d    = 1'b0;
		status_d    = status_q;
		out_value_d = out_value_q;
		position_d  = position_q;
		last_d      = last_q;
		wr.en       = 1'b0;
		wr.addr     = count_q[IDX_W-1:0];
		wr.data     = value;
		rd_addr     = idx_q[IDX_W-1:0];

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					value_d = value;
					idx_d   = '0;
					case (req_type)
						REQ_APPEND, REQ_INSERT: begin
							if (count_q == CNT_W'(DEPTH)) begin
								strobe_d    = 1'b1;
								status_d    = ST_FULL;
								out_value_d = value;
								position_d  = POS_W'(count_q);
								last_d      = 1'b1;
							end else if (req_type == REQ_APPEND || count_q == '0) begin
								// Nothing to search or shift: store at the tail now.
								wr.en       = 1'b1;
								count_d     = count_q + CNT_W'(1);
								strobe_d    = 1'b1;
								status_d    = ST_STORED;
								out_value_d = value;
								position_d  = POS_W'(count_q);
								last_d      = 1'b1;
							end else begin
								state_d = S_SCAN_RD;
							end
						end
						REQ_READ: begin
							if (count_q == '0) begin
								strobe_d    = 1'b1;
								status_d    = ST_EMPTY;
								out_value_d = '0;
								position_d  = '0;
								last_d      = 1'b1;
							end else begin
								state_d = S_READ_RD;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (greater) begin
					pos_d   = idx_q;
					idx_d   = count_q;
					state_d = S_SHIFT_RD;
				end else if (idx_inc == count_q) begin
					pos_d   = count_q;
					state_d = S_PUT;
				end else begin
					idx_d   = idx_inc;
					state_d = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				// idx_q is the slot being filled; fetch the entry just below it.
				rd_addr = idx_dec[IDX_W-1:0];
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				wr.en   = 1'b1;
				wr.addr = idx_q[IDX_W-1:0];
				wr.data = rd_data;
				idx_d   = idx_dec;
				state_d = (idx_dec > pos_q) ? S_SHIFT_RD : S_PUT;
			end
			S_PUT: begin
				wr.en       = 1'b1;
				wr.addr     = pos_q[IDX_W-1:0];
				wr.data     = value_q;
				count_d     = count_q + CNT_W'(1);
				strobe_d    = 1'b1;
				status_d    = ST_STORED;
				out_value_d = value_q;
				position_d  = POS_W'(pos_q);
				last_d      = 1'b1;
				state_d     = S_IDLE;
			end
			S_READ_RD: begin
				state_d = S_READ_OUT;
			end
			S_READ_OUT: begin
				strobe_d    = 1'b1;
				status_d    = ST_ELEM;
				out_value_d = rd_data;
				position_d  = POS_W'(idx_q);
				last_d      = (idx_inc == count_q);
				idx_d       = idx_inc;
				state_d     = (idx_inc == count_q) ? S_IDLE : S_READ_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q       <= idx_d;
		pos_q       <= pos_d;
		value_q     <= value_d;
		status_q    <= status_d;
		out_value_q <= out_value_d;
		position_q  <= position_d;
		last_q      <= last_d;
	end

	assign busy      = (state_q != S_IDLE);
	assign strobe    = strobe_q;
	assign status    = status_q;
	assign out_value = out_value_q;
	assign position  = position_q;
	assign last      = last_q;

endmodule

`default_nettype wire
